// File: src/dmc_pkg.sv
// Shared types, constants and helper functions of the depth-first maze carver.
package dmc_pkg;

    localparam int GRID_COLS  = 16;
    localparam int GRID_ROWS  = 16;
    localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
    localparam int COORD_W    = 4;
    localparam int CELL_W     = 2 * COORD_W;
    localparam int DEPTH_W    = CELL_W + 1;
    localparam int WALL_W     = 4;
    localparam int ENTRY_W    = WALL_W + 1;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_STEP  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_IDLE  = 2'd3;

    localparam logic [2:0] EV_STARTED = 3'd0;
    localparam logic [2:0] EV_CARVED  = 3'd1;
    localparam logic [2:0] EV_BACK    = 3'd2;
    localparam logic [2:0] EV_FINISH  = 3'd3;
    localparam logic [2:0] EV_READ    = 3'd4;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    localparam logic [WALL_W-1:0] WALL_ALL = 4'b1111;

    typedef struct packed {
        logic [1:0]         func;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [7:0]         random_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         event_res;
        logic [COORD_W-1:0] from_x;
        logic [COORD_W-1:0] from_y;
        logic [COORD_W-1:0] to_x;
        logic [COORD_W-1:0] to_y;
        logic [WALL_W-1:0]  wall_bits;
    } t_out_item;

    typedef struct packed {
        logic              found;
        logic [1:0]        dir;
        logic [CELL_W-1:0] next_cell;
    } t_pick;

    // Cell index of the neighbor in the given direction (wraps; callers mask the edges).
    function automatic logic [CELL_W-1:0] nbr_cell(input logic [CELL_W-1:0] cur,
                                                   input logic [1:0] dir);
        logic [CELL_W-1:0] res;
        unique case (dir)
            DIR_UP:    res = cur - CELL_W'(GRID_COLS);
            DIR_RIGHT: res = cur + CELL_W'(1);
            DIR_DOWN:  res = cur + CELL_W'(GRID_COLS);
            default:   res = cur - CELL_W'(1);
        endcase
        return res;
    endfunction

    function automatic logic [WALL_W-1:0] wall_mask(input logic [1:0] dir);
        return WALL_W'(1) << dir;
    endfunction

endpackage

// File: src/dfs_maze_carver_top.sv
// Top level of the depth-first maze carver: command sequencer around the cell and path memories.
// The idle code, or a step on an empty path, gives its result in the cycle after acceptance;
// a read passes ST_READ; a step ST_SCAN (serial neighbor reads), ST_PICK, then ST_LINK or ST_POP
// (the last pop ends in ST_PICK); a start ST_CLEAR (sweeping one entry per cycle) and ST_INIT.
// Throughput: one item at a time; busy stays high until the item's result has been issued.
// Reset (synchronous, active low) starts a clearing pass over all 256 cells with busy high.
// Results are strobed for one cycle on o_valid; the receiver cannot stall them.
module dfs_maze_carver_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  dmc_pkg::t_in_item i_item,
    output logic              busy,
    output logic              o_valid,
    output dmc_pkg::t_out_item o_result
);
    import dmc_pkg::*;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for an item
    localparam logic [2:0] ST_CLEAR = 3'd1;  // sweeping walls closed, visited cleared
    localparam logic [2:0] ST_INIT  = 3'd2;  // marking the start cell and pushing it
    localparam logic [2:0] ST_READ  = 3'd3;  // read data of a wall query arrives
    localparam logic [2:0] ST_SCAN  = 3'd4;  // reading four neighbors and the current cell
    localparam logic [2:0] ST_PICK  = 3'd5;  // open current wall, or pop the path
    localparam logic [2:0] ST_LINK  = 3'd6;  // open neighbor wall, push it, move there
    localparam logic [2:0] ST_POP   = 3'd7;  // new top of the path arrives

    // Control state.
    logic [2:0]         r_state, n_state;
    logic [CELL_W-1:0]  r_cnt, n_cnt;
    logic [2:0]         r_scan, n_scan;
    logic               r_pend, n_pend;
    logic [CELL_W-1:0]  r_cur, n_cur;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic               r_o_valid, n_o_valid;

    // Payload registers.
    logic [CELL_W-1:0]  r_cmd_cell, n_cmd_cell;
    logic [7:0]         r_rnd, n_rnd;
    t_out_item          r_out, n_out;
    logic [ENTRY_W-1:0] r_slot [0:4];

    // Memory ports. Cell entry is {visited, walls}.
    logic               cell_we;
    logic [CELL_W-1:0]  cell_waddr;
    logic [ENTRY_W-1:0] cell_wdata;
    logic [CELL_W-1:0]  cell_raddr;
    logic [ENTRY_W-1:0] cell_rdata;
    logic               stk_we;
    logic [CELL_W-1:0]  stk_waddr;
    logic [CELL_W-1:0]  stk_wdata;
    logic [CELL_W-1:0]  stk_raddr;
    logic [CELL_W-1:0]  stk_rdata;

    logic               accept;
    logic [3:0]         nbr_visited;
    logic [DEPTH_W-1:0] depth_dec;
    logic [DEPTH_W-1:0] depth_dec2;
    t_pick              pick;

    dmc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CELL_COUNT)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata (cell_wdata),
        .i_raddr (cell_raddr),
        .o_rdata (cell_rdata)
    );

    dmc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_path_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // Visited bits of the four neighbors as captured during the scan.
    assign nbr_visited = {r_slot[3][WALL_W], r_slot[2][WALL_W],
                          r_slot[1][WALL_W], r_slot[0][WALL_W]};

    dmc_pick u_pick (
        .i_cur     (r_cur),
        .i_visited (nbr_visited),
        .i_rnd     (r_rnd),
        .o_pick    (pick)
    );

    function automatic t_out_item make_out(input logic [2:0] ev,
                                           input logic [CELL_W-1:0] from_cell,
                                           input logic [CELL_W-1:0] to_cell,
                                           input logic [WALL_W-1:0] walls);
        t_out_item res;
        res.event_res = ev;
        res.from_x    = from_cell[COORD_W-1:0];
        res.from_y    = from_cell[CELL_W-1:COORD_W];
        res.to_x      = to_cell[COORD_W-1:0];
        res.to_y      = to_cell[CELL_W-1:COORD_W];
        res.wall_bits = walls;
        return res;
    endfunction

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    assign depth_dec  = r_depth - DEPTH_W'(1);
    assign depth_dec2 = r_depth - DEPTH_W'(2);

    // The path memory's read data is used only on a pop; its address is the new top of the path.
    assign stk_raddr = depth_dec2[CELL_W-1:0];

    // All reads of an item are issued only after the writes of the previous item have
    // landed, and a step performs its writes only after its reads, so no entry is
    // read and written in the same cycle.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_scan     = r_scan;
        n_pend     = r_pend;
        n_cur      = r_cur;
        n_depth    = r_depth;
        n_o_valid  = 1'b0;
        n_cmd_cell = r_cmd_cell;
        n_rnd      = r_rnd;
        n_out      = r_out;

        cell_we    = 1'b0;
        cell_waddr = r_cnt;
        cell_wdata = {1'b0, WALL_ALL};
        cell_raddr = {i_item.cell_y, i_item.cell_x};
        stk_we     = 1'b0;
        stk_waddr  = r_depth[CELL_W-1:0];
        stk_wdata  = pick.next_cell;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd_cell = {i_item.cell_y, i_item.cell_x};
                    n_rnd      = i_item.random_value;
                    unique case (i_item.func)
                        FUNC_START: begin
                            n_cnt   = '0;
                            n_pend  = 1'b1;
                            n_state = ST_CLEAR;
                        end
                        FUNC_READ: begin
                            n_state = ST_READ;
                        end
                        FUNC_STEP: begin
                            if (r_depth == '0) begin
                                n_o_valid = 1'b1;
                                n_out     = make_out(EV_FINISH, r_cur, r_cur, '0);
                            end else begin
                                n_scan  = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            n_o_valid = 1'b1;
                            n_out     = make_out(EV_FINISH, r_cur, r_cur, '0);
                        end
                    endcase
                end
            end

            ST_CLEAR: begin
                cell_we = 1'b1;
                n_cnt   = r_cnt + CELL_W'(1);
                if (r_cnt == CELL_W'(CELL_COUNT - 1)) begin
                    n_state = r_pend ? ST_INIT : ST_IDLE;
                end
            end

            ST_INIT: begin
                cell_we    = 1'b1;
                cell_waddr = r_cmd_cell;
                cell_wdata = {1'b1, WALL_ALL};
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = r_cmd_cell;
                n_cur      = r_cmd_cell;
                n_depth    = DEPTH_W'(1);
                n_pend     = 1'b0;
                n_o_valid  = 1'b1;
                n_out      = make_out(EV_STARTED, r_cmd_cell, r_cmd_cell, '0);
                n_state    = ST_IDLE;
            end

            ST_READ: begin
                n_o_valid = 1'b1;
                n_out     = make_out(EV_READ, r_cmd_cell, r_cur, cell_rdata[WALL_W-1:0]);
                n_state   = ST_IDLE;
            end

            ST_SCAN: begin
                // Scan slots 0..3 are the neighbors up, right, down, left; slot 4 is
                // the current cell. Read data is registered and arrives in the cycle after its address.
                if (r_scan == 3'd4) begin
                    cell_raddr = r_cur;
                end else begin
                    cell_raddr = nbr_cell(r_cur, r_scan[1:0]);
                end
                n_scan = r_scan + 3'd1;
                if (r_scan == 3'd5) begin
                    n_state = ST_PICK;
                end
            end

            ST_PICK: begin
                if (pick.found) begin
                    cell_we    = 1'b1;
                    cell_waddr = r_cur;
                    cell_wdata = {1'b1, r_slot[4][WALL_W-1:0] & ~wall_mask(pick.dir)};
                    n_state    = ST_LINK;
                end else begin
                    n_depth = depth_dec;
                    if (depth_dec == '0) begin
                        n_o_valid = 1'b1;
                        n_out     = make_out(EV_FINISH, r_cur, r_cur, '0);
                        n_state   = ST_IDLE;
                    end else begin
                        n_state = ST_POP;
                    end
                end
            end

            ST_LINK: begin
                cell_we    = 1'b1;
                cell_waddr = pick.next_cell;
                cell_wdata = {1'b1, r_slot[{1'b0, pick.dir}][WALL_W-1:0]
                                    & ~wall_mask(pick.dir ^ 2'b10)};
                if (!r_depth[DEPTH_W-1]) begin
                    stk_we  = 1'b1;
                    n_depth = r_depth + DEPTH_W'(1);
                end
                n_cur     = pick.next_cell;
                n_o_valid = 1'b1;
                n_out     = make_out(EV_CARVED, r_cur, pick.next_cell, '0);
                n_state   = ST_IDLE;
            end

            ST_POP: begin
                n_cur     = stk_rdata;
                n_o_valid = 1'b1;
                n_out     = make_out(EV_BACK, r_cur, stk_rdata, '0);
                n_state   = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_cnt     <= '0;
            r_scan    <= '0;
            r_pend    <= 1'b0;
            r_cur     <= '0;
            r_depth   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_scan    <= n_scan;
            r_pend    <= n_pend;
            r_cur     <= n_cur;
            r_depth   <= n_depth;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd_cell <= n_cmd_cell;
        r_rnd      <= n_rnd;
        r_out      <= n_out;
        if (r_state == ST_SCAN && r_scan != 3'd0) begin
            r_slot[r_scan - 3'd1] <= cell_rdata;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_result = r_out;

endmodule

// File: src/dmc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/dmc_pick.sv
// Neighbor selection: gathers open neighbors and picks one by the random draw.
module dmc_pick (
    input  logic [dmc_pkg::CELL_W-1:0] i_cur,
    input  logic [3:0]                 i_visited,
    input  logic [7:0]                 i_rnd,
    output dmc_pkg::t_pick             o_pick
);
    import dmc_pkg::*;

    // Residue mod 3 by folding base-4 digits, since 4 is 1 mod 3.
    function automatic logic [1:0] mod3(input logic [7:0] v);
        logic [3:0] s0;
        logic [2:0] s1;
        logic [2:0] s2;
        s0 = 4'(v[7:6]) + 4'(v[5:4]) + 4'(v[3:2]) + 4'(v[1:0]);
        s1 = 3'(s0[3:2]) + 3'(s0[1:0]);
        s2 = 3'(s1[2]) + 3'(s1[1:0]);
        if (s2 >= 3'd3) begin
            s2 = s2 - 3'd3;
        end
        return s2[1:0];
    endfunction

    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [3:0]         exists;
    logic [3:0]         avail;
    logic [2:0]         count;
    logic [1:0]         idx;
    logic [1:0]         seen;
    logic               done;
    logic [1:0]         dir;

    assign cx = i_cur[COORD_W-1:0];
    assign cy = i_cur[CELL_W-1:COORD_W];

    always_comb begin
        exists[DIR_UP]    = (cy != '0);
        exists[DIR_RIGHT] = (cx != COORD_W'(GRID_COLS - 1));
        exists[DIR_DOWN]  = (cy != COORD_W'(GRID_ROWS - 1));
        exists[DIR_LEFT]  = (cx != '0);
        avail = exists & ~i_visited;
        count = 3'(avail[0]) + 3'(avail[1]) + 3'(avail[2]) + 3'(avail[3]);

        case (count)
            3'd2:    idx = {1'b0, i_rnd[0]};
            3'd3:    idx = mod3(i_rnd);
            3'd4:    idx = i_rnd[1:0];
            default: idx = 2'd0;
        endcase

        seen = 2'd0;
        done = 1'b0;
        dir  = DIR_UP;
        for (int i = 0; i < 4; i++) begin
            if (avail[i] && !done) begin
                if (seen == idx) begin
                    dir  = 2'(i);
                    done = 1'b1;
                end
                seen = seen + 2'd1;
            end
        end

        o_pick.found     = (count != 3'd0);
        o_pick.dir       = dir;
        o_pick.next_cell = nbr_cell(i_cur, dir);
    end

endmodule

// File: src/dmc_checker.sv
// Port-level checker of the maze carver and its bind to the top level.
module dmc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input dmc_pkg::t_in_item  i_item,
    input logic               busy,
    input logic               o_valid,
    input dmc_pkg::t_out_item o_result
);
    import dmc_pkg::*;

    logic acc;
    assign acc = start && !busy;

    // A result is only issued once the block is ready for the next item.
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobed while busy");

    // Only a wall query reports walls.
    a_walls_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.event_res != EV_READ) |-> (o_result.wall_bits == '0))
        else $error("wall bits set on a non-read result");

    // The idle code answers in the next cycle with the finished event.
    a_idle_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_item.func == FUNC_IDLE) |=>
            (o_valid && o_result.event_res == EV_FINISH))
        else $error("idle code not answered");

    // A wall query answers, after its registered memory read, with the queried cell.
    a_read_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_item.func == FUNC_READ) |=> ##1
            (o_valid && o_result.event_res == EV_READ
             && o_result.from_x == $past(i_item.cell_x, 2)
             && o_result.from_y == $past(i_item.cell_y, 2)))
        else $error("read answer wrong or late");

    // A start reports the same cell as origin and destination.
    a_start_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.event_res == EV_STARTED) |->
            (o_result.from_x == o_result.to_x && o_result.from_y == o_result.to_y))
        else $error("start result moved");

endmodule

bind dfs_maze_carver_top dmc_checker u_dmc_checker (.*);
